>>> rtl/esc_pkg.sv
// Shared types and constants for the expression syntax checker.
// No dependencies; the decoder, the core, the top and the bench import this package.
`timescale 1ns / 1ps

package esc_pkg;

	// Sizing
	localparam int MAX_DEPTH  = 255;
	localparam int INDEX_BITS = 16;
	localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);
	localparam int POS_BITS   = 16;
	localparam int WIDE_BITS  = (INDEX_BITS > POS_BITS) ? INDEX_BITS : POS_BITS;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	// Request kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// ASCII codes of interest
	localparam logic [7:0] ASC_OPEN  = 8'h28; // (
	localparam logic [7:0] ASC_CLOSE = 8'h29; // )
	localparam logic [7:0] ASC_DOT   = 8'h2E; // .
	localparam logic [7:0] ASC_PLUS  = 8'h2B; // +
	localparam logic [7:0] ASC_MINUS = 8'h2D; // -
	localparam logic [7:0] ASC_STAR  = 8'h2A; // *
	localparam logic [7:0] ASC_SLASH = 8'h2F; // /
	localparam logic [7:0] ASC_ZERO  = 8'h30;
	localparam logic [7:0] ASC_NINE  = 8'h39;
	localparam logic [7:0] ASC_TAB   = 8'h09;
	localparam logic [7:0] ASC_CR    = 8'h0D;
	localparam logic [7:0] ASC_SPACE = 8'h20;

	// Class of a single input character
	typedef enum logic [2:0] {
		CH_SPACE,
		CH_DIGIT,
		CH_DOT,
		CH_OPEN,
		CH_CLOSE,
		CH_OPER,
		CH_OTHER
	} char_class_t;

	// Class of the last token
	typedef enum logic [1:0] {
		CLS_START = 2'd0,
		CLS_NUM   = 2'd1,
		CLS_PAR   = 2'd2,
		CLS_OPR   = 2'd3
	} token_class_t;

	// Decoded request as held in the input register
	typedef struct packed {
		logic        kind;
		char_class_t cls;
	} esc_item_t;

endpackage

>>> rtl/esc_if.sv
// Handshake channels of the expression syntax checker: character requests in,
// verdicts out. Depends on nothing.
`timescale 1ns / 1ps

interface esc_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;

	modport source (output valid, kind, char_code, input ready);
	modport sink   (input valid, kind, char_code, output ready);
endinterface

interface esc_out_if;
	logic        valid;
	logic        ready;
	logic        syntax_ok;
	logic [15:0] error_position;

	modport source (output valid, syntax_ok, error_position, input ready);
	modport sink   (input valid, syntax_ok, error_position, output ready);
endinterface

>>> rtl/expression_syntax_checker_top.sv
// Top level of the expression syntax checker.
// Depends on esc_pkg, esc_if, esc_decode and esc_core.
`timescale 1ns / 1ps

// Streams an arithmetic expression one character request at a time and returns
// one verdict per expression, on the end request: syntax_ok, or the index among
// non-space characters where the first error sits (saturating at 65535). One
// request is taken every clock cycle unless an end request waits in the input
// register; a character updates the token state in the cycle after it is taken;
// an end request passes the input register, then the output register. The
// single-entry output register stalls end requests only while an earlier
// verdict waits; characters wait behind them. An end request resets the checker.

module expression_syntax_checker_top import esc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	esc_in_if.sink    in_ch,
	esc_out_if.source out_ch
);

	char_class_t cls;
	esc_item_t   item;

	// Classify the character before it is registered
	esc_decode u_decode (
		.char_code (in_ch.char_code),
		.cls       (cls)
	);

	assign item.kind = in_ch.kind;
	assign item.cls  = cls;

	esc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_ch.valid),
		.req_ready (in_ch.ready),
		.req_item  (item),
		.res       (out_ch)
	);

endmodule

>>> rtl/esc_decode.sv
// Character classifier: maps an ASCII byte onto the checker's character class.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_decode import esc_pkg::*; (
	input  logic [7:0]  char_code,
	output char_class_t cls
);

	// Whitespace is tab through carriage return, plus space
	always_comb begin
		if (char_code == ASC_SPACE || (char_code >= ASC_TAB && char_code <= ASC_CR)) begin
			cls = CH_SPACE;
		end else if (char_code >= ASC_ZERO && char_code <= ASC_NINE) begin
			cls = CH_DIGIT;
		end else if (char_code == ASC_DOT) begin
			cls = CH_DOT;
		end else if (char_code == ASC_OPEN) begin
			cls = CH_OPEN;
		end else if (char_code == ASC_CLOSE) begin
			cls = CH_CLOSE;
		end else if (char_code == ASC_PLUS || char_code == ASC_MINUS ||
				char_code == ASC_STAR || char_code == ASC_SLASH) begin
			cls = CH_OPER;
		end else begin
			cls = CH_OTHER;
		end
	end

endmodule

>>> rtl/esc_core.sv
// Checker core: input register, token state update and output register.
// Depends on esc_pkg and esc_out_if.
`timescale 1ns / 1ps

module esc_core import esc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  esc_item_t  req_item,
	esc_out_if.source  res
);

	// Input register
	logic      valid_s1;
	esc_item_t item_s1;
	logic      adv_s1;

	// Checker state
	token_class_t          cls_q, cls_n;
	logic [DEPTH_BITS-1:0] depth_q, depth_n;
	logic                  in_num_q, in_num_n;
	logic [1:0]            dots_q, dots_n;
	logic                  last_dot_q, last_dot_n;
	logic [INDEX_BITS-1:0] num_last_q, num_last_n;
	logic                  err_q, err_n;
	logic [INDEX_BITS-1:0] index_q, index_n;
	logic [INDEX_BITS-1:0] stop_q, stop_n;

	// Verdict for an end request
	logic                  fin_err;
	logic [INDEX_BITS-1:0] fin_stop;
	logic [WIDE_BITS-1:0]  fin_wide;
	logic [POS_BITS-1:0]   fin_pos;

	// Output register
	logic                  out_valid_q;
	logic                  ok_q;
	logic [POS_BITS-1:0]   pos_q;

	logic num_bad;
	logic index_full;

	// Only an end request waits on output: while a verdict sits there unread
	assign adv_s1    = valid_s1 && (item_s1.kind == KIND_CHAR || !out_valid_q || res.ready);
	assign req_ready = !valid_s1 || adv_s1;

	assign num_bad    = (dots_q > 2'd1) || last_dot_q;
	assign index_full = (index_q == {INDEX_BITS{1'b1}});

	// Next state of the checker
	always_comb begin
		cls_n      = cls_q;
		depth_n    = depth_q;
		in_num_n   = in_num_q;
		dots_n     = dots_q;
		last_dot_n = last_dot_q;
		num_last_n = num_last_q;
		err_n      = err_q;
		index_n    = index_q;
		stop_n     = stop_q;
		fin_err    = err_q;
		fin_stop   = stop_q;

		if (item_s1.kind == KIND_END) begin
			// pending number first, then open depth or trailing operator
			if (!err_q && in_num_q && num_bad) begin
				fin_err  = 1'b1;
				fin_stop = num_last_q;
			end else if (!err_q && (depth_q != '0 || cls_q == CLS_OPR)) begin
				fin_err  = 1'b1;
				fin_stop = index_q;
			end
			cls_n      = CLS_START;
			depth_n    = '0;
			in_num_n   = 1'b0;
			dots_n     = 2'd0;
			last_dot_n = 1'b0;
			num_last_n = '0;
			err_n      = 1'b0;
			index_n    = '0;
			stop_n     = '0;
		end else if (!err_q && item_s1.cls != CH_SPACE) begin
			if (in_num_q && (item_s1.cls == CH_DIGIT || item_s1.cls == CH_DOT)) begin
				// number goes on
				if (item_s1.cls == CH_DOT) begin
					if (dots_q != 2'd3) begin
						dots_n = dots_q + 2'd1;
					end
					last_dot_n = 1'b1;
				end else begin
					last_dot_n = 1'b0;
				end
				num_last_n = index_q;
				if (!index_full) begin
					index_n = index_q + 1'b1;
				end
			end else if (in_num_q && num_bad) begin
				// number ended badly: report at its last character
				in_num_n = 1'b0;
				err_n    = 1'b1;
				stop_n   = num_last_q;
			end else begin
				in_num_n = 1'b0;
				unique case (item_s1.cls)
					CH_OPEN: begin
						if (cls_q == CLS_NUM || depth_q >= DEPTH_BITS'(MAX_DEPTH)) begin
							err_n  = 1'b1;
							stop_n = index_q;
						end else begin
							cls_n   = CLS_PAR;
							depth_n = depth_q + 1'b1;
						end
					end
					CH_CLOSE: begin
						if (depth_q == '0 || cls_q == CLS_PAR) begin
							err_n  = 1'b1;
							stop_n = index_q;
						end else begin
							depth_n = depth_q - 1'b1;
						end
					end
					CH_DIGIT: begin
						cls_n      = CLS_NUM;
						in_num_n   = 1'b1;
						dots_n     = 2'd0;
						last_dot_n = 1'b0;
						num_last_n = index_q;
					end
					CH_OPER: begin
						if (cls_q == CLS_OPR || cls_q == CLS_START) begin
							err_n  = 1'b1;
							stop_n = index_q;
						end else begin
							cls_n = CLS_OPR;
						end
					end
					default: begin
						// stray dot or unknown character
						err_n  = 1'b1;
						stop_n = index_q;
					end
				endcase
				if (!err_n && !index_full) begin
					index_n = index_q + 1'b1;
				end
			end
		end
	end

	// Clamp the reported position to the output width
	always_comb begin
		fin_wide = WIDE_BITS'(fin_stop);
		if (fin_wide > WIDE_BITS'(POS_MAX)) begin
			fin_pos = POS_MAX;
		end else begin
			fin_pos = fin_wide[POS_BITS-1:0];
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req_item;
		end
	end

	// Checker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q      <= CLS_START;
			depth_q    <= '0;
			in_num_q   <= 1'b0;
			dots_q     <= 2'd0;
			last_dot_q <= 1'b0;
			num_last_q <= '0;
			err_q      <= 1'b0;
			index_q    <= '0;
			stop_q     <= '0;
		end else if (adv_s1) begin
			cls_q      <= cls_n;
			depth_q    <= depth_n;
			in_num_q   <= in_num_n;
			dots_q     <= dots_n;
			last_dot_q <= last_dot_n;
			num_last_q <= num_last_n;
			err_q      <= err_n;
			index_q    <= index_n;
			stop_q     <= stop_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.kind == KIND_END) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.kind == KIND_END) begin
			ok_q  <= !fin_err;
			pos_q <= fin_err ? fin_pos : '0;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.syntax_ok      = ok_q;
	assign res.error_position = pos_q;

endmodule

>>> dv/tb_top.sv
// Self-checking bench for the expression syntax checker: streams character
// requests, predicts each verdict and checks it. Depends on esc_pkg, esc_if and the RTL top.
`timescale 1ns / 1ps

module tb_top import esc_pkg::*; ();

	localparam int RESET_CYCLES = 11;
	localparam int STALL_LIMIT  = 1000;
	localparam int SETTLE       = 8;
	localparam int RANDOM_ITEMS = 560;

	typedef struct packed {
		logic       kind;
		logic [7:0] code;
	} request_t;

	typedef struct packed {
		logic                ok;
		logic [POS_BITS-1:0] pos;
	} verdict_t;

	// Bytes used to build and break expressions
	localparam logic [7:0] SYNTAX_BYTES [10] = '{ASC_OPEN, ASC_CLOSE, ASC_DOT, ASC_PLUS,
		ASC_MINUS, ASC_STAR, ASC_SLASH, ASC_ZERO, ASC_NINE, ASC_SPACE};
	localparam logic [7:0] OPERATORS [4] = '{ASC_PLUS, ASC_MINUS, ASC_STAR, ASC_SLASH};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	esc_in_if  in_if ();
	esc_out_if out_if ();

	expression_syntax_checker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	always #5 clk = ~clk;

	request_t   chars_to_send [$];
	verdict_t   verdicts_due [$];
	logic [7:0] expr_buf [$];
	int         send_gap_pct = 0;
	int         recv_stall_pct = 0;
	int         fail_count = 0;
	int         idle_cycles = 0;
	int         queued_items = 0;
	request_t   next_req;
	verdict_t   want;

	// Predictor state for the expression in progress
	token_class_t    last_tok;
	int unsigned     depth;
	bit              num_open;
	int unsigned     dots;
	bit              dot_last;
	longint unsigned num_end_pos;
	bit              err_seen;
	longint unsigned next_pos;
	longint unsigned err_pos;

	function automatic void clear_state();
		last_tok    = CLS_START;
		depth       = 0;
		num_open    = 1'b0;
		dots        = 0;
		dot_last    = 1'b0;
		num_end_pos = 0;
		err_seen    = 1'b0;
		next_pos    = 0;
		err_pos     = 0;
	endfunction

	function automatic void flag_error(longint unsigned pos);
		err_seen = 1'b1;
		err_pos  = pos;
	endfunction

	function automatic void bump_pos();
		if (next_pos < ((64'd1 << INDEX_BITS) - 1)) begin
			next_pos++;
		end
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= ASC_ZERO && c <= ASC_NINE;
	endfunction

	// Token tracking for one non-end request
	function automatic void track_char(logic [7:0] c);
		longint unsigned pos = next_pos;
		if (err_seen || c == ASC_SPACE || (c >= ASC_TAB && c <= ASC_CR)) begin
			return;
		end
		// digits and dots extend a number; anything else closes it
		if (num_open) begin
			if (is_digit(c) || c == ASC_DOT) begin
				if (c == ASC_DOT) begin
					if (dots < 3) dots++;
					dot_last = 1'b1;
				end else begin
					dot_last = 1'b0;
				end
				num_end_pos = pos;
				bump_pos();
				return;
			end
			num_open = 1'b0;
			if (dots > 1 || dot_last) begin
				flag_error(num_end_pos);
				return;
			end
		end
		if (c == ASC_OPEN) begin
			if (last_tok == CLS_NUM || depth >= MAX_DEPTH) begin
				flag_error(pos);
				return;
			end
			last_tok = CLS_PAR;
			depth++;
		end else if (c == ASC_CLOSE) begin
			if (depth == 0 || last_tok == CLS_PAR) begin
				flag_error(pos);
				return;
			end
			depth--;
		end else if (is_digit(c)) begin
			last_tok    = CLS_NUM;
			num_open    = 1'b1;
			dots        = 0;
			dot_last    = 1'b0;
			num_end_pos = pos;
		end else if (c == ASC_PLUS || c == ASC_MINUS || c == ASC_STAR || c == ASC_SLASH) begin
			if (last_tok == CLS_OPR || last_tok == CLS_START) begin
				flag_error(pos);
				return;
			end
			last_tok = CLS_OPR;
		end else begin
			flag_error(pos);
			return;
		end
		bump_pos();
	endfunction

	// End request: final checks, queue the verdict, start over
	function automatic void close_expression();
		verdict_t v;
		if (!err_seen && num_open && (dots > 1 || dot_last)) begin
			flag_error(num_end_pos);
		end
		if (!err_seen && (depth != 0 || last_tok == CLS_OPR)) begin
			flag_error(next_pos);
		end
		v.ok  = !err_seen;
		v.pos = !err_seen ? '0 : (err_pos > POS_MAX) ? POS_MAX : err_pos[POS_BITS-1:0];
		verdicts_due.push_back(v);
		clear_state();
	endfunction

	// Stimulus helpers
	function automatic void push_req(logic kind, logic [7:0] code);
		request_t r;
		r.kind = kind;
		r.code = code;
		chars_to_send.push_back(r);
		queued_items++;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			push_req(KIND_CHAR, s[i]);
		end
		push_req(KIND_END, 8'($urandom_range(255)));
	endfunction

	function automatic logic [7:0] pick_blank();
		int b = $urandom_range(14, 9);
		return (b == 14) ? ASC_SPACE : 8'(b);
	endfunction

	// occasional whitespace in front of a character
	function automatic void put_ch(logic [7:0] c);
		if ($urandom_range(9) == 0) expr_buf.push_back(pick_blank());
		expr_buf.push_back(c);
	endfunction

	function automatic void gen_number();
		repeat ($urandom_range(3, 1)) put_ch(ASC_ZERO + 8'($urandom_range(9)));
		if ($urandom_range(9) < 3) begin
			put_ch(ASC_DOT);
			repeat ($urandom_range(2, 1)) put_ch(ASC_ZERO + 8'($urandom_range(9)));
		end
	endfunction

	// well-formed expression with random nesting
	function automatic void gen_expr(int lvl);
		int terms = $urandom_range(4, 1);
		for (int t = 0; t < terms; t++) begin
			if (t != 0) put_ch(OPERATORS[$urandom_range(3)]);
			if (lvl > 0 && $urandom_range(3) == 0) begin
				put_ch(ASC_OPEN);
				gen_expr(lvl - 1);
				put_ch(ASC_CLOSE);
			end else begin
				gen_number();
			end
		end
	endfunction

	function automatic void mutate();
		int idx;
		logic [7:0] sym = SYNTAX_BYTES[$urandom_range(9)];
		if (expr_buf.size() == 0) return;
		idx = $urandom_range(expr_buf.size() - 1);
		case ($urandom_range(4))
			0: expr_buf[idx] = 8'($urandom_range(255));
			1: expr_buf[idx] = sym;
			2: expr_buf.insert(idx, sym);
			3: expr_buf.delete(idx);
			default: expr_buf.push_back(sym);
		endcase
	endfunction

	function automatic void queue_buf();
		foreach (expr_buf[i]) push_req(KIND_CHAR, expr_buf[i]);
		push_req(KIND_END, 8'($urandom_range(255)));
	endfunction

	// mostly clean expressions, some broken ones, some byte noise
	task automatic random_block(int n);
		int target = queued_items + n;
		int r;
		while (queued_items < target) begin
			expr_buf.delete();
			r = $urandom_range(99);
			if (r < 85) begin
				gen_expr(3);
				if (r >= 60) repeat ($urandom_range(2, 1)) mutate();
			end else begin
				repeat ($urandom_range(8)) begin
					expr_buf.push_back($urandom_range(1) ? 8'($urandom_range(255))
						: SYNTAX_BYTES[$urandom_range(9)]);
				end
			end
			queue_buf();
		end
	endtask

	// hold the sender until every verdict is back
	task automatic drain();
		wait (chars_to_send.size() == 0);
		@(posedge clk);
		wait (!in_if.valid);
		wait (verdicts_due.size() == 0);
	endtask

	// Request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else if (!in_if.valid || in_if.ready) begin
			if (chars_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				next_req = chars_to_send.pop_front();
				in_if.valid     <= 1'b1;
				in_if.kind      <= next_req.kind;
				in_if.char_code <= next_req.code;
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// Verdict receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on accepted requests, check accepted verdicts
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				if (in_if.kind == KIND_END) close_expression();
				else track_char(in_if.char_code);
			end
			if (out_if.valid && out_if.ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: unexpected verdict ok=%0b pos=%0d", $time,
						out_if.syntax_ok, out_if.error_position);
					fail_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (out_if.syntax_ok !== want.ok) begin
						$display("%0t: syntax_ok expected %0b actual %0b", $time,
							want.ok, out_if.syntax_ok);
						fail_count++;
					end
					if (out_if.error_position !== want.pos) begin
						$display("%0t: error_position expected %0d actual %0d", $time,
							want.pos, out_if.error_position);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		in_if.valid     = 1'b0;
		in_if.kind      = KIND_CHAR;
		in_if.char_code = 8'h00;
		out_if.ready    = 1'b0;
		clear_state();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: clean, open after number, empty pair, stray close, two dots,
		// trailing dot, leading and doubled operators, unknown byte, open depth,
		// trailing operator, lone dot, empty expression
		push_text("( 9.0)\t*2");
		push_text("1(");
		push_text("()");
		push_text(")");
		push_text("1..2");
		push_text("7.");
		push_text("+");
		push_text("1-/");
		push_text("#");
		push_text("(1");
		push_text("3-");
		push_text(".");
		push_text("");
		drain();

		send_gap_pct = 52;
		random_block(RANDOM_ITEMS / 4);
		send_gap_pct = 0;
		recv_stall_pct = 52;
		random_block(RANDOM_ITEMS / 4);
		drain();
		send_gap_pct = 7;
		recv_stall_pct = 7;
		random_block(RANDOM_ITEMS / 4);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		random_block(RANDOM_ITEMS / 4);
		drain();

		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && verdicts_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> expression_syntax_checker_top.f
rtl/esc_pkg.sv
rtl/esc_if.sv
rtl/esc_decode.sv
rtl/esc_core.sv
rtl/expression_syntax_checker_top.sv
dv/tb_top.sv
